FILE: hw/rtl/cip_pkg.sv
// Package with shared types and constants for the complex integer power block.
`timescale 1ns / 1ps
`default_nettype none
package cip_pkg;
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_REFUSED = 2'd1;
  localparam logic [1:0] STATUS_OVF     = 2'd2;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_TOL = 3'd0;
  localparam int TOL_W = 16;

  // Datapath operations requested by the controller.
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_MULA  = 3'd2;
  localparam logic [2:0] OP_SQR   = 3'd3;
  localparam logic [2:0] OP_MAG   = 3'd4;
  localparam logic [2:0] OP_DIVST = 3'd5;
  localparam logic [2:0] OP_DIVIT = 3'd6;
  localparam logic [2:0] OP_DIVEN = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic       mul_start;
  } cip_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic tol_fail;
  } cip_stat_t;
endpackage
`default_nettype wire

FILE: hw/rtl/complex_integer_power.sv
// Top level of the complex integer power block: channels, register port and units.
//
//  channel | direction | ports
//  in      | request   | in_valid, in_stall, in_base_re, in_base_im, in_power_exp
//  out     | result    | out_valid, out_stall, out_result_re, out_result_im, out_status
//  cfg     | registers | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One request at a time. Each squaring or multiply holds the shared four-step
// complex multiplier until its product is written back, and each exponent bit
// adds a dispatch step in the controller. A negative power adds two serial
// restoring divides, one for each part of the reciprocal. Reset is synchronous
// and active low and clears the controller and zero_tolerance. A stalled result
// holds on out_ and no new request is taken until it is delivered.
`timescale 1ns / 1ps
`default_nettype none
module complex_integer_power import cip_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int EXP_WIDTH  = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [DATA_WIDTH-1:0] in_base_re,
  input  wire logic [DATA_WIDTH-1:0] in_base_im,
  input  wire logic [EXP_WIDTH-1:0]  in_power_exp,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [DATA_WIDTH-1:0]      out_result_re,
  output logic [DATA_WIDTH-1:0]      out_result_im,
  output logic [1:0]                 out_status,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  logic [TOL_W-1:0] tol_r;
  cip_cmd_t  cmd;
  cip_stat_t stat;
  logic [DATA_WIDTH-1:0] dp_re, dp_im;
  logic dp_ovf, refused;

  // The only register sits at byte address zero.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= '0;
    else if (psel && penable && pwrite && paddr == REG_ZERO_TOL) tol_r <= pwdata[TOL_W-1:0];
  end
  assign prdata = (paddr == REG_ZERO_TOL) ? 32'(tol_r) : '0;

  cip_ctrl #(.EXP_WIDTH(EXP_WIDTH)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_power_exp, .out_valid, .out_stall,
    .cmd, .stat, .refused);

  cip_datapath #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .base_re(in_base_re), .base_im(in_base_im), .tol(tol_r),
    .stat, .res_re(dp_re), .res_im(dp_im), .ovf(dp_ovf));

  // A refused reciprocal overrides any earlier overflow.
  assign out_result_re = refused ? '0 : dp_re;
  assign out_result_im = refused ? '0 : dp_im;
  assign out_status = refused ? STATUS_REFUSED : (dp_ovf ? STATUS_OVF : STATUS_OK);
endmodule
`default_nettype wire

FILE: hw/rtl/cip_datapath.sv
// Datapath: complex multiplier over several cycles, magnitude and serial divider.
`timescale 1ns / 1ps
`default_nettype none
module cip_datapath import cip_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cip_cmd_t              cmd,
  input  wire logic [DATA_WIDTH-1:0] base_re,
  input  wire logic [DATA_WIDTH-1:0] base_im,
  input  wire logic [TOL_W-1:0]      tol,
  output cip_stat_t                  stat,
  output logic [DATA_WIDTH-1:0]      res_re,
  output logic [DATA_WIDTH-1:0]      res_im,
  output logic                       ovf
);
  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW + 2;           // exact complex product width
  localparam int MW = 2 * DW + 1;           // magnitude width (non-negative)
  localparam int NW = DW + 2 * FRAC_BITS;   // dividend width
  localparam int CW = $clog2(NW + 1);
  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [DW-1:0] acc_re_r, acc_im_r, bas_re_r, bas_im_r;
  logic                 ovf_r;
  // Multiplier sequencing: four partial products, one per cycle.
  logic [2:0]           mstep_r;
  logic                 msqr_r;
  logic signed [PW-1:0] sum_re_r, sum_im_r;
  logic signed [2*DW-1:0] prod_r;
  logic                 mbusy_r;

  logic signed [DW-1:0] ma, mb;
  always_comb begin
    ma = msqr_r ? bas_re_r : acc_re_r;
    mb = bas_re_r;
    case (mstep_r)
      3'd0: begin ma = msqr_r ? bas_re_r : acc_re_r; mb = bas_re_r; end
      3'd1: begin ma = msqr_r ? bas_im_r : acc_im_r; mb = bas_im_r; end
      3'd2: begin ma = msqr_r ? bas_re_r : acc_re_r; mb = bas_im_r; end
      3'd3: begin ma = msqr_r ? bas_im_r : acc_im_r; mb = bas_re_r; end
      default: begin ma = acc_re_r; mb = acc_re_r; end
    endcase
  end

  function automatic logic signed [DW:0] rnd_sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    logic signed [DW-1:0] o;
    logic f;
    r = (v + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    f = 1'b0;
    o = r[DW-1:0];
    if (r > PW'(SMAX)) begin o = SMAX; f = 1'b1; end
    else if (r < PW'(SMIN)) begin o = SMIN; f = 1'b1; end
    return {f, o};
  endfunction

  logic signed [DW:0] rs_re, rs_im;
  assign rs_re = rnd_sat(sum_re_r);
  assign rs_im = rnd_sat(sum_im_r);

  // Magnitude and divider.
  logic [MW-1:0]  mag_r;
  logic [NW-1:0]  num_r;
  logic [MW:0]    rem_r;
  logic [NW-1:0]  quo_r;
  logic [CW-1:0]  dcnt_r;
  logic           dim_r, dneg_r, dbusy_r, ddone_r;
  logic [MW:0]    rem_sh;
  assign rem_sh = {rem_r[MW-1:0], num_r[NW-1]};

  logic [DW-1:0] abs_re, abs_im;
  assign abs_re = acc_re_r[DW-1] ? DW'(-acc_re_r) : acc_re_r;
  assign abs_im = acc_im_r[DW-1] ? DW'(-acc_im_r) : acc_im_r;

  logic [2*DW-1:0] sq_re, sq_im;
  assign sq_re = abs_re * abs_re;
  assign sq_im = abs_im * abs_im;

  // Saturation of a signed quotient (magnitude q, sign s).
  function automatic logic [DW:0] qsat(input logic [NW-1:0] q, input logic s);
    logic [NW:0] lim;
    lim = s ? (NW+1)'({1'b1, {(DW-1){1'b0}}}) : (NW+1)'(SMAX);
    if ({1'b0, q} > lim) return {1'b1, s ? SMIN : SMAX};
    return {1'b0, s ? DW'(-q[DW-1:0]) : q[DW-1:0]};
  endfunction

  logic [DW:0] qs;
  assign qs = qsat(quo_r, dneg_r);
  logic signed [DW-1:0] quo_keep_r;
  logic tol_fail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0; dbusy_r <= 1'b0; ddone_r <= 1'b0; mstep_r <= '0; ovf_r <= 1'b0;
    end else begin
      ddone_r <= 1'b0;
      // The finished product is written back even when the next operation starts now.
      if (mbusy_r && mstep_r == 3'd5) begin
        ovf_r <= ovf_r | rs_re[DW] | rs_im[DW];
        if (msqr_r) begin bas_re_r <= rs_re[DW-1:0]; bas_im_r <= rs_im[DW-1:0]; end
        else begin acc_re_r <= rs_re[DW-1:0]; acc_im_r <= rs_im[DW-1:0]; end
      end
      if (cmd.mul_start) begin
        mbusy_r <= 1'b1; mstep_r <= '0; msqr_r <= (cmd.op == OP_SQR);
        sum_re_r <= '0; sum_im_r <= '0;
      end else if (mbusy_r) begin
        mstep_r <= mstep_r + 3'd1;
        prod_r  <= ma * mb;
        case (mstep_r)
          3'd1: sum_re_r <= sum_re_r + PW'(prod_r);
          3'd2: sum_re_r <= sum_re_r - PW'(prod_r);
          3'd3: sum_im_r <= sum_im_r + PW'(prod_r);
          3'd4: sum_im_r <= sum_im_r + PW'(prod_r);
          default: ;
        endcase
        if (mstep_r == 3'd5) mbusy_r <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          bas_re_r <= base_re; bas_im_r <= base_im;
          ovf_r <= (FRAC_BITS >= DW - 1);
          acc_re_r <= (FRAC_BITS >= DW - 1) ? SMAX : DW'(1) << FRAC_BITS;
          acc_im_r <= '0;
        end
        OP_MAG: begin
          mag_r <= MW'(sq_re) + MW'(sq_im);
          dim_r <= 1'b0;
        end
        OP_DIVST: begin
          tol_fail_r <= (mag_r >> FRAC_BITS) <= MW'(tol);
          num_r  <= NW'(dim_r ? abs_im : abs_re) << (2 * FRAC_BITS);
          dneg_r <= dim_r ? (acc_im_r != '0 && !acc_im_r[DW-1]) : acc_re_r[DW-1];
          rem_r <= '0; quo_r <= '0; dcnt_r <= CW'(NW); dbusy_r <= 1'b1;
        end
        OP_DIVEN: begin
          ovf_r <= ovf_r | qs[DW];
          if (dim_r) begin acc_re_r <= quo_keep_r; acc_im_r <= qs[DW-1:0]; end
          else quo_keep_r <= qs[DW-1:0];
          dim_r <= ~dim_r;
        end
        default: ;
      endcase
      // A divide left running after a refusal is restarted by the next divide start.
      if (dbusy_r && cmd.op != OP_DIVST) begin
        num_r <= num_r << 1;
        if (rem_sh >= {1'b0, mag_r}) begin
          rem_r <= rem_sh - {1'b0, mag_r}; quo_r <= {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh; quo_r <= {quo_r[NW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - CW'(1);
        if (dcnt_r == CW'(1)) begin dbusy_r <= 1'b0; ddone_r <= 1'b1; end
      end
    end
  end

  assign stat.mul_done = mbusy_r && mstep_r == 3'd5;
  assign stat.div_done = ddone_r;
  assign stat.tol_fail = tol_fail_r;
  assign res_re = acc_re_r;
  assign res_im = acc_im_r;
  assign ovf    = ovf_r;
endmodule
`default_nettype wire

FILE: hw/rtl/cip_ctrl.sv
// Controller state machine sequencing square-and-multiply and the reciprocal.
`timescale 1ns / 1ps
`default_nettype none
module cip_ctrl import cip_pkg::*; #(
  parameter int EXP_WIDTH = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [EXP_WIDTH-1:0] in_power_exp,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output cip_cmd_t                  cmd,
  input  wire cip_stat_t            stat,
  output logic                      refused
);
  localparam logic [3:0] S_IDLE = 4'd0, S_STEP = 4'd1, S_MULW = 4'd2, S_SQRW = 4'd3,
    S_MAG = 4'd4, S_DST = 4'd5, S_CHK = 4'd6, S_DIVW = 4'd7, S_DEN = 4'd8, S_OUT = 4'd9;
  logic [3:0] state_r, state_nxt;
  logic [EXP_WIDTH-1:0] mag_r, mag_nxt, mabs;
  logic neg_r, neg_nxt, half_r, half_nxt, ref_r, ref_nxt;

  assign mabs = in_power_exp[EXP_WIDTH-1] ? EXP_WIDTH'(-in_power_exp) : in_power_exp;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign refused = ref_r;

  always_comb begin
    state_nxt = state_r; mag_nxt = mag_r; neg_nxt = neg_r; half_nxt = half_r;
    ref_nxt = ref_r; cmd.op = OP_NONE; cmd.mul_start = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op = OP_LOAD; mag_nxt = mabs; neg_nxt = in_power_exp[EXP_WIDTH-1];
        ref_nxt = 1'b0; state_nxt = S_STEP;
      end
      S_STEP: begin
        if (mag_r == '0) state_nxt = neg_r ? S_MAG : S_OUT;
        else if (mag_r[0]) begin
          cmd.op = OP_MULA; cmd.mul_start = 1'b1; state_nxt = S_MULW;
        end else begin
          cmd.op = OP_SQR; cmd.mul_start = 1'b1; state_nxt = S_SQRW;
          mag_nxt = mag_r >> 1;
        end
      end
      S_MULW: if (stat.mul_done) begin
        mag_nxt = mag_r >> 1;
        if ((mag_r >> 1) != '0) begin
          cmd.op = OP_SQR; cmd.mul_start = 1'b1; state_nxt = S_SQRW;
        end else state_nxt = S_STEP;
      end
      S_SQRW: if (stat.mul_done) state_nxt = S_STEP;
      S_MAG: begin cmd.op = OP_MAG; half_nxt = 1'b0; state_nxt = S_DST; end
      S_DST: begin cmd.op = OP_DIVST; state_nxt = half_r ? S_DIVW : S_CHK; end
      S_CHK: if (stat.tol_fail) begin ref_nxt = 1'b1; state_nxt = S_OUT; end
             else state_nxt = S_DIVW;
      S_DIVW: if (stat.div_done) state_nxt = S_DEN;
      S_DEN: begin
        cmd.op = OP_DIVEN;
        if (half_r) state_nxt = S_OUT;
        else begin half_nxt = 1'b1; state_nxt = S_DST; end
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ref_r <= 1'b0; half_r <= 1'b0; neg_r <= 1'b0; mag_r <= '0;
    end else begin
      state_r <= state_nxt; mag_r <= mag_nxt; neg_r <= neg_nxt;
      half_r <= half_nxt; ref_r <= ref_nxt;
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped under stall");
  a_ref_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && refused |-> neg_r) else $error("refusal without negative exponent");
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the complex integer power block.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import cip_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int EW = 8;

  // Wide signed type for exact products, rounding and the reciprocal divide.
  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [DW-1:0] re;
    logic [DW-1:0] im;
    logic [1:0]    status;
  } power_result_t;

  localparam wide_t MAX_Q = 128'sd2147483647;
  localparam wide_t MIN_Q = -128'sd2147483648;
  localparam wide_t ONE_Q = 128'sd65536;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [DW-1:0] in_base_re;
  logic [DW-1:0] in_base_im;
  logic [EW-1:0] in_power_exp;
  logic          out_valid;
  logic          out_stall;
  logic [DW-1:0] out_result_re;
  logic [DW-1:0] out_result_im;
  logic [1:0]    out_status;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  complex_integer_power DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_base_re   (in_base_re),
    .in_base_im   (in_base_im),
    .in_power_exp (in_power_exp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result_re(out_result_re),
    .out_result_im(out_result_im),
    .out_status   (out_status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Tolerance as the block currently holds it, and results still owed by the block.
  logic [TOL_W-1:0] tol_shadow;
  power_result_t    pending_powers[$];
  int               fail_count;
  int               receiver_hold;   // when nonzero, the receiver holds one long stall set by this value
  bit               receiver_quiet;  // when set, the receiver never stalls

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Saturate to the data width and note any overflow.
  function automatic wide_t clamp_q(input wide_t v, inout bit ovf);
    if (v > MAX_Q) begin
      ovf = 1'b1;
      return MAX_Q;
    end
    if (v < MIN_Q) begin
      ovf = 1'b1;
      return MIN_Q;
    end
    return v;
  endfunction

  // Round half up in the fraction, then saturate.
  function automatic wide_t round_q(input wide_t v, inout bit ovf);
    return clamp_q((v + (128'sd1 <<< (FB - 1))) >>> FB, ovf);
  endfunction

  // Predicts the block's answer for one request under the current tolerance.
  function automatic power_result_t complex_power(input logic [DW-1:0] b_re,
                                                  input logic [DW-1:0] b_im,
                                                  input logic [EW-1:0] e);
    power_result_t res;
    wide_t br, bi, ar, ai, tr, ti, mag2;
    bit ovf;
    int n;
    ovf = 1'b0;
    br = wide_t'($signed(b_re));
    bi = wide_t'($signed(b_im));
    ar = ONE_Q;
    ai = 0;
    n = $signed(e);
    if (n < 0) n = -n;
    while (n != 0) begin
      if (n[0]) begin
        tr = round_q(ar * br - ai * bi, ovf);
        ti = round_q(ar * bi + ai * br, ovf);
        ar = tr;
        ai = ti;
      end
      n = n >> 1;
      if (n != 0) begin
        tr = round_q(br * br - bi * bi, ovf);
        ti = round_q(br * bi + bi * br, ovf);
        br = tr;
        bi = ti;
      end
    end
    if (e[EW-1]) begin
      mag2 = ar * ar + ai * ai;
      // Too close to zero: the reciprocal is refused outright.
      if ((mag2 >>> FB) <= wide_t'(tol_shadow)) begin
        res.re = '0;
        res.im = '0;
        res.status = STATUS_REFUSED;
        return res;
      end
      // Signed division truncates toward zero, as the block does.
      tr = clamp_q((ar <<< (2 * FB)) / mag2, ovf);
      ti = clamp_q(-((ai <<< (2 * FB)) / mag2), ovf);
      ar = tr;
      ai = ti;
    end
    res.re = ar[DW-1:0];
    res.im = ai[DW-1:0];
    res.status = ovf ? STATUS_OVF : STATUS_OK;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result checker: every accepted result is matched with the oldest prediction.
  always @(posedge clk) begin
    power_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_powers.size() == 0) begin
        $error("result with no request outstanding: re=%h im=%h status=%0d",
               out_result_re, out_result_im, out_status);
        fail_count++;
      end else begin
        exp_res = pending_powers.pop_front();
        if (out_result_re !== exp_res.re) begin
          $error("result_re expected %h actual %h", exp_res.re, out_result_re);
          fail_count++;
        end
        if (out_result_im !== exp_res.im) begin
          $error("result_im expected %h actual %h", exp_res.im, out_result_im);
          fail_count++;
        end
        if (out_status !== exp_res.status) begin
          $error("status expected %0d actual %0d", exp_res.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, a long hold when requested, none in quiet mode.
  initial begin
    int g;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_hold > 0) begin
        out_stall = 1'b1;
        repeat (receiver_hold) @(negedge clk);
        receiver_hold = 0;
        out_stall = 1'b0;
      end else if (!receiver_quiet && $urandom_range(0, 3) == 0) begin
        g = pick_gap();
        if (g > 0) begin
          out_stall = 1'b1;
          repeat (g) @(negedge clk);
          out_stall = 1'b0;
        end
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Offers one request, optionally after a gap, and records its prediction on acceptance.
  task automatic send_power(input logic [DW-1:0] b_re, input logic [DW-1:0] b_im,
                            input logic [EW-1:0] e, input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_base_re   = b_re;
    in_base_im   = b_im;
    in_power_exp = e;
    in_valid     = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_powers.push_back(complex_power(b_re, b_im, e));
    @(negedge clk);
  endtask

  // Drops valid and waits until every predicted result has been delivered.
  task automatic drain();
    in_valid = 1'b0;
    while (pending_powers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write: setup cycle then access cycle. Only called while the block is idle.
  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = REG_ZERO_TOL;
    pwdata  = {16'h0, v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tol_shadow = v;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Random base: full range, near unit magnitude, tiny, or zero.
  function automatic logic [DW-1:0] pick_base();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom;
    if (r < 7) return DW'($signed($urandom_range(0, 2 * 81920)) - 81920);
    if (r < 9) return DW'($signed($urandom_range(0, 1024)) - 512);
    return '0;
  endfunction

  // Exponents mostly small, sometimes anywhere in the range.
  function automatic logic [EW-1:0] pick_exp();
    if ($urandom_range(0, 3) == 0) return EW'($urandom);
    return EW'($signed($urandom_range(0, 16)) - 8);
  endfunction

  // Extremes of every field and each special case, with the tolerance at reset value.
  task automatic test_directed();
    send_power(32'h0, 32'h0, 8'd0, 0);           // zero to the power zero gives one
    send_power(32'h8000_0000, 32'h7fff_ffff, 8'd0, 0);
    send_power(32'h0001_0000, 32'h0, 8'd1, 0);
    send_power(32'h0001_0000, 32'h0, 8'd127, 0);
    send_power(32'h0001_0000, 32'h0, 8'h80, 0);  // most negative exponent
    send_power(32'h0, 32'h0001_0000, 8'd3, 0);
    send_power(32'h7fff_ffff, 32'h7fff_ffff, 8'd2, 0); // saturates
    send_power(32'h8000_0000, 32'h8000_0000, 8'd1, 0);
    send_power(32'h8000_0000, 32'h0, 8'd2, 0);
    send_power(32'h0, 32'h0, 8'hff, 0);          // reciprocal of zero is refused
    send_power(32'h0, 32'h0, 8'd5, 0);
    send_power(32'h0000_8000, 32'h0000_8000, 8'hff, 0);
    send_power(32'h0002_0000, 32'hffff_0000, 8'hfd, 0);
    send_power(32'h7fff_ffff, 32'h0, 8'hff, 0);
    send_power(32'h0000_0001, 32'h0, 8'hff, 0);  // too close to zero: the reciprocal is refused
    send_power(32'hffff_8000, 32'h0001_8000, 8'd7, 0);
    send_power(32'h7fff_ffff, 32'h0, 8'h80, 0);  // overflow before the reciprocal
    send_power(32'h0001_0000, 32'h0001_0000, 8'd64, 0);
    drain();
  endtask

  // Tolerance settings at the extremes and in between, each with negative powers.
  task automatic test_tolerance();
    logic [TOL_W-1:0] tols[4];
    tols = '{16'hffff, 16'h0001, 16'h0100, 16'h0000};
    foreach (tols[k]) begin
      write_tolerance(k == 2 ? TOL_W'($urandom) : tols[k]);
      for (int j = 0; j < 20; j++)
        send_power(pick_base(), pick_base(), EW'(-$urandom_range(1, 4)), pick_gap());
      send_power(32'h0001_0000, 32'h0, 8'hff, 0);
      send_power(32'h0000_ff00, 32'h0, 8'hff, 0);
      drain();
    end
  endtask

  // Bulk random requests over several tolerance settings; some stretches without idling.
  task automatic test_random();
    for (int p = 0; p < 4; p++) begin
      write_tolerance(p == 3 ? 16'h0 : TOL_W'($urandom_range(0, 65535)));
      receiver_quiet = (p == 1);
      for (int j = 0; j < 480; j++)
        send_power(pick_base(), pick_base(), pick_exp(), p == 1 ? 0 : pick_gap());
      drain();
    end
    receiver_quiet = 1'b0;
  endtask

  // Receiver holds off for a long stretch while requests keep coming, then the
  // sender pauses until everything is back, then sends a second batch without the hold.
  task automatic test_backpressure();
    receiver_hold = 600;
    for (int j = 0; j < 24; j++)
      send_power(pick_base(), pick_base(), pick_exp(), 0);
    drain();
    for (int j = 0; j < 24; j++)
      send_power(pick_base(), pick_base(), pick_exp(), 0);
    drain();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_base_re     = '0;
    in_base_im     = '0;
    in_power_exp   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    tol_shadow     = '0;
    fail_count     = 0;
    receiver_hold  = 0;
    receiver_quiet = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_tolerance();
    test_random();
    test_backpressure();

    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending_powers.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/cip_pkg.sv
hw/rtl/cip_datapath.sv
hw/rtl/cip_ctrl.sv
hw/rtl/complex_integer_power.sv
tb/sv/tb.sv
